// File: hdl/bwma_pkg.sv
// ----------------------------------------------------------------------------
// bwma_pkg
// Shared types and constants of the binned weighted mean accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package bwma_pkg;

  // default sizes of the counters and of a sample
  localparam int DEF_COUNT_BITS  = 20;
  localparam int DEF_SAMPLE_BITS = 16;

  // configuration port shape
  localparam int CFG_BITS     = 16;
  localparam int CFG_IDX_BITS = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BOTTOM_CUTOFF = 2'd0,
    REG_TOP_CUTOFF    = 2'd1,
    REG_MIDDLE_LOW    = 2'd2,
    REG_MIDDLE_HIGH   = 2'd3
  } cfg_reg_t;

  // one division per mean, in this order
  typedef enum logic [2:0] {
    JOB_TOTAL  = 3'd0,
    JOB_DEV    = 3'd1,
    JOB_MIDDLE = 3'd2,
    JOB_BOTTOM = 3'd3,
    JOB_TOP    = 3'd4
  } job_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_LOAD = 2'd1,
    S_RUN  = 2'd2
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic acc;    // accumulate the accepted sample
    logic snap;   // last sample: latch results, clear the bin
    logic start;  // start the division for job
    logic store;  // write the quotient of job to its mean
    job_t job;
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic div_done;
  } ctrl_status_t;

endpackage

`default_nettype wire

// File: hdl/bwma_ctrl.sv
// ----------------------------------------------------------------------------
// bwma_ctrl
// Controller: input and output handshakes and the sequence of the five
// mean divisions that follow the last sample of a bin.
// ----------------------------------------------------------------------------
`default_nettype none

module bwma_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic                  end_of_bin,
  output logic                       in_stall,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output bwma_pkg::ctrl_cmd_t        cmd,
  input  wire bwma_pkg::ctrl_status_t status
);
  import bwma_pkg::*;

  state_t state;
  state_t state_next;
  job_t   job;
  job_t   job_next;
  logic   in_accept;
  logic   last_job;

  // a last sample waits while the means of the previous bin are pending
  assign in_stall  = end_of_bin & ((state != S_IDLE) | out_valid);
  assign in_accept = in_valid & ~in_stall;
  assign last_job  = (job == JOB_TOP);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept && end_of_bin) state_next = S_LOAD;
      end
      S_LOAD: state_next = S_RUN;
      S_RUN: begin
        if (status.div_done) state_next = last_job ? S_IDLE : S_LOAD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // job sequence
  always_comb begin
    unique case (job)
      JOB_TOTAL:  job_next = JOB_DEV;
      JOB_DEV:    job_next = JOB_MIDDLE;
      JOB_MIDDLE: job_next = JOB_BOTTOM;
      JOB_BOTTOM: job_next = JOB_TOP;
      JOB_TOP:    job_next = JOB_TOTAL;
      default:    job_next = JOB_TOTAL;
    endcase
  end

  // outputs
  always_comb begin
    cmd.acc   = in_accept;
    cmd.snap  = in_accept & end_of_bin;
    cmd.start = (state == S_LOAD);
    cmd.store = (state == S_RUN) & status.div_done;
    cmd.job   = job;
  end

  // state, job and result valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      job       <= JOB_TOTAL;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.store) job <= job_next;
      if (cmd.store && last_job) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/bwma_div.sv
// ----------------------------------------------------------------------------
// bwma_div
// Restoring divider, one quotient bit per cycle. The quotient is known to
// fit in SAMPLE_BITS bits because every sum is at most count times a sample.
// ----------------------------------------------------------------------------
`default_nettype none

module bwma_div #(
  parameter int COUNT_BITS  = 20,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [COUNT_BITS+SAMPLE_BITS-1:0] dividend,
  input  wire logic [COUNT_BITS-1:0]             divisor,
  output logic                                   done,
  output logic [SAMPLE_BITS-1:0]                 quotient
);
  localparam int SUM_BITS  = COUNT_BITS + SAMPLE_BITS;
  localparam int STEP_BITS = $clog2(SAMPLE_BITS);

  logic [COUNT_BITS-1:0]  rem;
  logic [SAMPLE_BITS-1:0] low;
  logic [COUNT_BITS-1:0]  dsr;
  logic [STEP_BITS-1:0]   step;
  logic                   running;
  logic [COUNT_BITS:0]    trial;
  logic                   fits;

  // one trial subtraction
  assign trial = {rem, low[SAMPLE_BITS-1]};
  assign fits  = (trial >= {1'b0, dsr});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + 1'b1;
        if (step == STEP_BITS'(SAMPLE_BITS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend[SUM_BITS-1:SAMPLE_BITS];
      low      <= dividend[SAMPLE_BITS-1:0];
      dsr      <= divisor;
      quotient <= '0;
    end else if (running) begin
      rem      <= fits ? COUNT_BITS'(trial - {1'b0, dsr}) : trial[COUNT_BITS-1:0];
      low      <= {low[SAMPLE_BITS-2:0], 1'b0};
      quotient <= {quotient[SAMPLE_BITS-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// File: hdl/bwma_datapath.sv
// ----------------------------------------------------------------------------
// bwma_datapath
// Class compares, bin accumulators, configuration registers, the snapshot
// of a finished bin and the result registers, with the shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

module bwma_datapath #(
  parameter int COUNT_BITS  = 20,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [bwma_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [bwma_pkg::CFG_BITS-1:0]  cfg_data,
  input  wire logic [SAMPLE_BITS-1:0]         sample,
  input  wire bwma_pkg::ctrl_cmd_t            cmd,
  output bwma_pkg::ctrl_status_t              status,
  output logic [COUNT_BITS-1:0]               total_count,
  output logic [SAMPLE_BITS-1:0]              total_mean,
  output logic [SAMPLE_BITS-1:0]              deviation_mean,
  output logic [COUNT_BITS-1:0]               middle_count,
  output logic [SAMPLE_BITS-1:0]              middle_mean,
  output logic [COUNT_BITS-1:0]               bottom_count,
  output logic [SAMPLE_BITS-1:0]              bottom_mean,
  output logic [COUNT_BITS-1:0]               top_count,
  output logic [SAMPLE_BITS-1:0]              upper_mean,
  output logic [SAMPLE_BITS-1:0]              first_sample,
  output logic                                overflow
);
  import bwma_pkg::*;

  localparam int SUM_BITS = COUNT_BITS + SAMPLE_BITS;
  localparam logic [SAMPLE_BITS-1:0] HALF    = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
  localparam logic [SAMPLE_BITS-1:0] QUARTER = SAMPLE_BITS'(1) << (SAMPLE_BITS - 2);
  localparam logic [SAMPLE_BITS-1:0] THREE_Q = HALF + QUARTER;

  // configuration
  logic [SAMPLE_BITS-1:0] bottom_cutoff, top_cutoff, middle_low, middle_high;

  // bin accumulators
  logic [COUNT_BITS-1:0]  all_count, mid_count, low_count, high_count;
  logic [SUM_BITS-1:0]    all_sum, deviation_sum, mid_sum, low_sum, high_sum;
  logic [SAMPLE_BITS-1:0] kept_first;
  logic                   dropped_flag;

  logic [COUNT_BITS-1:0]  all_count_next, mid_count_next, low_count_next, high_count_next;
  logic [SUM_BITS-1:0]    all_sum_next, deviation_sum_next, mid_sum_next;
  logic [SUM_BITS-1:0]    low_sum_next, high_sum_next;
  logic [SAMPLE_BITS-1:0] kept_first_next;
  logic                   dropped_flag_next;

  // snapshot of the sums of a finished bin
  logic [SUM_BITS-1:0]    snap_all, snap_dev, snap_mid, snap_low, snap_high;

  // divider hookup
  logic [SUM_BITS-1:0]    div_dividend;
  logic [COUNT_BITS-1:0]  div_divisor;
  logic [SAMPLE_BITS-1:0] div_quotient;
  logic                   div_done;
  logic [SAMPLE_BITS-1:0] mean;

  logic [SAMPLE_BITS-1:0] deviation;
  logic                   is_mid, is_low, is_high, full;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bottom_cutoff <= QUARTER;
      top_cutoff    <= THREE_Q;
      middle_low    <= QUARTER;
      middle_high   <= THREE_Q;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BOTTOM_CUTOFF: bottom_cutoff <= SAMPLE_BITS'(cfg_data);
        REG_TOP_CUTOFF:    top_cutoff    <= SAMPLE_BITS'(cfg_data);
        REG_MIDDLE_LOW:    middle_low    <= SAMPLE_BITS'(cfg_data);
        REG_MIDDLE_HIGH:   middle_high   <= SAMPLE_BITS'(cfg_data);
      endcase
    end
  end

  // classification and distance from one half
  assign deviation = (sample >= HALF) ? (sample - HALF) : (HALF - sample);
  assign is_mid    = (sample >= middle_low) && (sample <= middle_high);
  assign is_low    = (sample <= bottom_cutoff);
  assign is_high   = (sample >= top_cutoff);
  assign full      = &all_count;

  // accumulator next values
  always_comb begin
    all_count_next     = all_count;
    mid_count_next     = mid_count;
    low_count_next     = low_count;
    high_count_next    = high_count;
    all_sum_next       = all_sum;
    deviation_sum_next = deviation_sum;
    mid_sum_next       = mid_sum;
    low_sum_next       = low_sum;
    high_sum_next      = high_sum;
    kept_first_next    = kept_first;
    dropped_flag_next  = dropped_flag;
    if (cmd.acc) begin
      if (full) begin
        dropped_flag_next = 1'b1;
      end else begin
        if (all_count == '0) kept_first_next = sample;
        all_count_next     = all_count + 1'b1;
        all_sum_next       = all_sum + SUM_BITS'(sample);
        deviation_sum_next = deviation_sum + SUM_BITS'(deviation);
        if (is_mid) begin
          mid_count_next = mid_count + 1'b1;
          mid_sum_next   = mid_sum + SUM_BITS'(sample);
        end
        if (is_low) begin
          low_count_next = low_count + 1'b1;
          low_sum_next   = low_sum + SUM_BITS'(sample);
        end
        if (is_high) begin
          high_count_next = high_count + 1'b1;
          high_sum_next   = high_sum + SUM_BITS'(sample);
        end
      end
    end
  end

  // accumulators, cleared after the last sample of a bin
  always_ff @(posedge clk) begin
    if (rst || cmd.snap) begin
      all_count     <= '0;
      mid_count     <= '0;
      low_count     <= '0;
      high_count    <= '0;
      all_sum       <= '0;
      deviation_sum <= '0;
      mid_sum       <= '0;
      low_sum       <= '0;
      high_sum      <= '0;
      kept_first    <= '0;
      dropped_flag  <= 1'b0;
    end else if (cmd.acc) begin
      all_count     <= all_count_next;
      mid_count     <= mid_count_next;
      low_count     <= low_count_next;
      high_count    <= high_count_next;
      all_sum       <= all_sum_next;
      deviation_sum <= deviation_sum_next;
      mid_sum       <= mid_sum_next;
      low_sum       <= low_sum_next;
      high_sum      <= high_sum_next;
      kept_first    <= kept_first_next;
      dropped_flag  <= dropped_flag_next;
    end
  end

  // snapshot and count results of the finished bin
  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      snap_all     <= all_sum_next;
      snap_dev     <= deviation_sum_next;
      snap_mid     <= mid_sum_next;
      snap_low     <= low_sum_next;
      snap_high    <= high_sum_next;
      total_count  <= all_count_next;
      middle_count <= mid_count_next;
      bottom_count <= low_count_next;
      top_count    <= high_count_next;
      first_sample <= kept_first_next;
      overflow     <= dropped_flag_next;
    end
  end

  // operand select for the current job
  always_comb begin
    unique case (cmd.job)
      JOB_TOTAL:  begin div_dividend = snap_all;  div_divisor = total_count;  end
      JOB_DEV:    begin div_dividend = snap_dev;  div_divisor = total_count;  end
      JOB_MIDDLE: begin div_dividend = snap_mid;  div_divisor = middle_count; end
      JOB_BOTTOM: begin div_dividend = snap_low;  div_divisor = bottom_count; end
      JOB_TOP:    begin div_dividend = snap_high; div_divisor = top_count;    end
      default:    begin div_dividend = snap_all;  div_divisor = total_count;  end
    endcase
  end

  bwma_div #(
    .COUNT_BITS (COUNT_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .done    (div_done),
    .quotient(div_quotient)
  );

  assign status.div_done = div_done;

  // empty class gives a zero mean
  assign mean = (div_divisor == '0) ? '0 : div_quotient;

  // mean results
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      unique case (cmd.job)
        JOB_TOTAL:  total_mean     <= mean;
        JOB_DEV:    deviation_mean <= mean;
        JOB_MIDDLE: middle_mean    <= mean;
        JOB_BOTTOM: bottom_mean    <= mean;
        JOB_TOP:    upper_mean     <= mean;
        default:    total_mean     <= mean;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/binned_weighted_mean_accumulator.sv
// ----------------------------------------------------------------------------
// binned_weighted_mean_accumulator
// Per-bin counts and truncated means of allele-frequency samples, overall,
// by distance from one half, and for the middle, bottom and top classes.
//
//   channel  handshake            payload
//   -------  -------------------  ---------------------------------------
//   in       in_valid / in_stall  sample, end_of_bin
//   out      out_valid/out_stall  counts, means, first_sample, overflow
//   cfg      cfg_write            cfg_index, cfg_data
//
// A sample that does not end a bin is taken every cycle, always.
// The last sample of a bin starts five divisions on one shared restoring
// divider, one quotient bit per cycle; out_valid rises once the fifth is stored.
// Samples of the next bin are taken meanwhile; its last sample stalls until
// the previous result has been taken. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module binned_weighted_mean_accumulator #(
  parameter int COUNT_BITS  = bwma_pkg::DEF_COUNT_BITS,
  parameter int SAMPLE_BITS = bwma_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [bwma_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [bwma_pkg::CFG_BITS-1:0]     cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [SAMPLE_BITS-1:0]            sample,
  input  wire logic                              end_of_bin,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [COUNT_BITS-1:0]                  total_count,
  output logic [SAMPLE_BITS-1:0]                 total_mean,
  output logic [SAMPLE_BITS-1:0]                 deviation_mean,
  output logic [COUNT_BITS-1:0]                  middle_count,
  output logic [SAMPLE_BITS-1:0]                 middle_mean,
  output logic [COUNT_BITS-1:0]                  bottom_count,
  output logic [SAMPLE_BITS-1:0]                 bottom_mean,
  output logic [COUNT_BITS-1:0]                  top_count,
  output logic [SAMPLE_BITS-1:0]                 upper_mean,
  output logic [SAMPLE_BITS-1:0]                 first_sample,
  output logic                                   overflow
);
  import bwma_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // controller
  bwma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .end_of_bin(end_of_bin),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // datapath
  bwma_datapath #(
    .COUNT_BITS (COUNT_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sample        (sample),
    .cmd           (cmd),
    .status        (status),
    .total_count   (total_count),
    .total_mean    (total_mean),
    .deviation_mean(deviation_mean),
    .middle_count  (middle_count),
    .middle_mean   (middle_mean),
    .bottom_count  (bottom_count),
    .bottom_mean   (bottom_mean),
    .top_count     (top_count),
    .upper_mean    (upper_mean),
    .first_sample  (first_sample),
    .overflow      (overflow)
  );

endmodule

`default_nettype wire

// File: hdl/bwma_checker.sv
// ----------------------------------------------------------------------------
// bwma_checker
// Port-level checks of the accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bwma_checker #(
  parameter int COUNT_BITS  = 20,
  parameter int SAMPLE_BITS = 16
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_stall,
  input wire logic                   end_of_bin,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic [COUNT_BITS-1:0]  total_count,
  input wire logic [COUNT_BITS-1:0]  middle_count,
  input wire logic [SAMPLE_BITS-1:0] total_mean,
  input wire logic                   overflow
);

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(total_count) && $stable(total_mean))
    else $error("stalled result changed");

  // samples inside a bin never stall
  a_mid_bin_flow: assert property (@(posedge clk) disable iff (rst)
    in_valid && !end_of_bin |-> !in_stall)
    else $error("mid-bin sample stalled");

  // a last sample waits while the previous result is pending
  a_last_waits: assert property (@(posedge clk) disable iff (rst)
    in_valid && end_of_bin && out_valid |-> in_stall)
    else $error("last sample taken over a pending result");

  // drops happen only with a full count, and the middle class never exceeds the total
  a_count_sane: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!overflow || (&total_count)) && (middle_count <= total_count))
    else $error("inconsistent counts");

endmodule

bind binned_weighted_mean_accumulator bwma_checker #(
  .COUNT_BITS (COUNT_BITS),
  .SAMPLE_BITS(SAMPLE_BITS)
) u_bwma_checker (.*);

`default_nettype wire
